/* src/group_delay_finite_difference_macros.svh */
// Assertion helpers shared by the RTL.
`ifndef GROUP_DELAY_FINITE_DIFFERENCE_MACROS_SVH
`define GROUP_DELAY_FINITE_DIFFERENCE_MACROS_SVH

// Same-cycle implication.
`define GDFD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("gdfd assertion failed");

// Next-cycle implication.
`define GDFD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("gdfd assertion failed");

`endif

/* src/gdfd_pkg.sv */
package gdfd_pkg;

    localparam int PHASE_BITS = 32;
    localparam int OMEGA_BITS = 40;
    localparam int DELAY_BITS = 48;
    localparam int FRAC_SHIFT = 24;

    // dividend is |dphase| scaled by 2^FRAC_SHIFT
    localparam int NUM_BITS = PHASE_BITS + FRAC_SHIFT;
    localparam int CNT_BITS = $clog2(NUM_BITS);
    localparam int CMP_BITS = (NUM_BITS > DELAY_BITS) ? NUM_BITS : DELAY_BITS;

    localparam logic [DELAY_BITS-1:0] DELAY_POS_MAX = {1'b0, {(DELAY_BITS-1){1'b1}}};
    localparam logic [DELAY_BITS-1:0] DELAY_NEG_MAX = {1'b1, {(DELAY_BITS-1){1'b0}}};

    typedef logic [1:0] status_t;
    localparam status_t STATUS_OK   = 2'd0;
    localparam status_t STATUS_SAT  = 2'd1;
    localparam status_t STATUS_ZERO = 2'd2;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DIFF,
        S_DIV,
        S_FIX
    } state_t;

endpackage

/* src/group_delay_finite_difference.sv */
// Group delay of a phase sweep, -dphase/domega, one result per sweep point.
// Input channel s_*: phase (Q8.24), omega (Q32.8), last. Result channel m_*:
// delay (Q8.40), status, run_end. Both are valid/ready.
// Results run one point behind: the first request of a run gives nothing,
// each later one gives the result for the point before it, and the request
// marked last gives two (the second with run_end). A run of one point gives
// nothing.
// Each result goes through the steps S_DIFF (form the differences), S_DIV
// (one restoring divider step per quotient bit through a single shared
// subtractor) and S_FIX (saturate and sign the quotient).
// A zero frequency step skips the divider. s_ready is high only
// while the sequencer is idle; a request marked last holds it for two results.
// The result sits in an output register; when the receiver stalls the
// sequencer waits in its final step until that register is free. A held
// result does not block acceptance of a request while the sequencer is idle.
// Reset (aresetn low, synchronous) empties the output register and starts
// a new run.
module group_delay_finite_difference (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  logic signed [gdfd_pkg::PHASE_BITS-1:0] s_phase,
    input  logic        [gdfd_pkg::OMEGA_BITS-1:0] s_omega,
    input  logic                                 s_last,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [gdfd_pkg::DELAY_BITS-1:0] m_delay,
    output gdfd_pkg::status_t                    m_status,
    output logic                                 m_run_end
);
    import gdfd_pkg::*;

    `include "group_delay_finite_difference_macros.svh"

    state_t state_reg, state_next;

    logic [1:0]            points_seen_reg, points_seen_next;
    logic [PHASE_BITS-1:0] prev_phase_reg, prev_phase_next;
    logic [OMEGA_BITS-1:0] prev_omega_reg, prev_omega_next;
    logic [PHASE_BITS-1:0] older_phase_reg, older_phase_next;
    logic [OMEGA_BITS-1:0] older_omega_reg, older_omega_next;
    logic [PHASE_BITS-1:0] a_phase_reg, a_phase_next;
    logic [OMEGA_BITS-1:0] a_omega_reg, a_omega_next;
    logic [PHASE_BITS-1:0] b_phase_reg, b_phase_next;
    logic [OMEGA_BITS-1:0] b_omega_reg, b_omega_next;
    logic                  last_reg, last_next;
    logic                  second_reg, second_next;
    logic [NUM_BITS-1:0]   num_reg, num_next;
    logic [OMEGA_BITS-1:0] nw_reg, nw_next;
    logic [OMEGA_BITS-1:0] rem_reg, rem_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  neg_reg, neg_next;
    logic                  zero_reg, zero_next;
    logic                  m_valid_reg, m_valid_next;
    logic [DELAY_BITS-1:0] m_delay_reg, m_delay_next;
    status_t               m_status_reg, m_status_next;
    logic                  m_run_end_reg, m_run_end_next;

    logic                  in_acc;
    logic                  out_free;
    logic [PHASE_BITS:0]   dp;
    logic [OMEGA_BITS:0]   dw;
    logic [PHASE_BITS-1:0] np;
    logic [OMEGA_BITS-1:0] nw;
    logic                  nw_zero;
    logic [OMEGA_BITS:0]   rem_shift;
    logic [OMEGA_BITS:0]   rem_diff;
    logic                  qbit;
    logic [DELAY_BITS-1:0] lim;
    logic                  sat;
    logic [DELAY_BITS-1:0] qv;
    logic [DELAY_BITS-1:0] delay_val;

    assign s_ready   = (state_reg == S_IDLE);
    assign in_acc    = s_valid && s_ready;
    assign out_free  = !m_valid_reg || m_ready;
    assign m_valid   = m_valid_reg;
    assign m_delay   = m_delay_reg;
    assign m_status  = m_status_reg;
    assign m_run_end = m_run_end_reg;

    // differences at full width
    assign dp = {b_phase_reg[PHASE_BITS-1], b_phase_reg}
              - {a_phase_reg[PHASE_BITS-1], a_phase_reg};
    assign dw = {1'b0, b_omega_reg} - {1'b0, a_omega_reg};
    assign np = dp[PHASE_BITS] ? PHASE_BITS'((PHASE_BITS+1)'(0) - dp) : dp[PHASE_BITS-1:0];
    assign nw = dw[OMEGA_BITS] ? OMEGA_BITS'((OMEGA_BITS+1)'(0) - dw) : dw[OMEGA_BITS-1:0];
    assign nw_zero = (nw == '0);

    // shared restoring divider step
    assign rem_shift = {rem_reg, num_reg[NUM_BITS-1]};
    assign rem_diff  = rem_shift - {1'b0, nw_reg};
    assign qbit      = !rem_diff[OMEGA_BITS];

    // saturate and sign
    assign lim       = neg_reg ? DELAY_NEG_MAX : DELAY_POS_MAX;
    assign sat       = CMP_BITS'(num_reg) > CMP_BITS'(lim);
    assign qv        = sat ? lim : DELAY_BITS'(num_reg);
    assign delay_val = neg_reg ? (DELAY_BITS'(0) - qv) : qv;

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc && points_seen_reg != 2'd0) begin
                    state_next = S_DIFF;
                end
            end
            S_DIFF: begin
                state_next = nw_zero ? S_FIX : S_DIV;
            end
            S_DIV: begin
                if (cnt_reg == '0) begin
                    state_next = S_FIX;
                end
            end
            S_FIX: begin
                if (out_free) begin
                    state_next = (last_reg && !second_reg) ? S_DIFF : S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        points_seen_next = points_seen_reg;
        prev_phase_next  = prev_phase_reg;
        prev_omega_next  = prev_omega_reg;
        older_phase_next = older_phase_reg;
        older_omega_next = older_omega_reg;
        a_phase_next     = a_phase_reg;
        a_omega_next     = a_omega_reg;
        b_phase_next     = b_phase_reg;
        b_omega_next     = b_omega_reg;
        last_next        = last_reg;
        second_next      = second_reg;
        num_next         = num_reg;
        nw_next          = nw_reg;
        rem_next         = rem_reg;
        cnt_next         = cnt_reg;
        neg_next         = neg_reg;
        zero_next        = zero_reg;
        m_valid_next     = m_valid_reg && !m_ready;
        m_delay_next     = m_delay_reg;
        m_status_next    = m_status_reg;
        m_run_end_next   = m_run_end_reg;
        case (state_reg)
            S_IDLE: begin
                if (in_acc) begin
                    if (points_seen_reg == 2'd0) begin
                        if (!s_last) begin
                            prev_phase_next  = s_phase;
                            prev_omega_next  = s_omega;
                            points_seen_next = 2'd1;
                        end
                    end else begin
                        a_phase_next = (points_seen_reg == 2'd1) ? prev_phase_reg
                                                                 : older_phase_reg;
                        a_omega_next = (points_seen_reg == 2'd1) ? prev_omega_reg
                                                                 : older_omega_reg;
                        b_phase_next = s_phase;
                        b_omega_next = s_omega;
                        last_next    = s_last;
                        second_next  = 1'b0;
                        if (s_last) begin
                            points_seen_next = 2'd0;
                        end else begin
                            older_phase_next = prev_phase_reg;
                            older_omega_next = prev_omega_reg;
                            prev_phase_next  = s_phase;
                            prev_omega_next  = s_omega;
                            points_seen_next = 2'd2;
                        end
                    end
                end
            end
            S_DIFF: begin
                num_next  = {np, {FRAC_SHIFT{1'b0}}};
                nw_next   = nw;
                rem_next  = '0;
                cnt_next  = CNT_BITS'(NUM_BITS - 1);
                neg_next  = (dp[PHASE_BITS] == dw[OMEGA_BITS]);
                zero_next = nw_zero;
            end
            S_DIV: begin
                if (qbit) begin
                    rem_next = rem_diff[OMEGA_BITS-1:0];
                end else begin
                    rem_next = rem_shift[OMEGA_BITS-1:0];
                end
                num_next = {num_reg[NUM_BITS-2:0], qbit};
                cnt_next = cnt_reg - CNT_BITS'(1);
            end
            S_FIX: begin
                if (out_free) begin
                    m_valid_next   = 1'b1;
                    m_run_end_next = second_reg;
                    if (zero_reg) begin
                        m_delay_next  = '0;
                        m_status_next = STATUS_ZERO;
                    end else begin
                        m_delay_next  = delay_val;
                        m_status_next = sat ? STATUS_SAT : STATUS_OK;
                    end
                    if (last_reg && !second_reg) begin
                        // backward difference against the previous point
                        second_next  = 1'b1;
                        a_phase_next = prev_phase_reg;
                        a_omega_next = prev_omega_reg;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            points_seen_reg <= 2'd0;
            second_reg      <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            state_reg       <= state_next;
            points_seen_reg <= points_seen_next;
            second_reg      <= second_next;
            m_valid_reg     <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        prev_phase_reg  <= prev_phase_next;
        prev_omega_reg  <= prev_omega_next;
        older_phase_reg <= older_phase_next;
        older_omega_reg <= older_omega_next;
        a_phase_reg     <= a_phase_next;
        a_omega_reg     <= a_omega_next;
        b_phase_reg     <= b_phase_next;
        b_omega_reg     <= b_omega_next;
        last_reg        <= last_next;
        num_reg         <= num_next;
        nw_reg          <= nw_next;
        rem_reg         <= rem_next;
        cnt_reg         <= cnt_next;
        neg_reg         <= neg_next;
        zero_reg        <= zero_next;
        m_delay_reg     <= m_delay_next;
        m_status_reg    <= m_status_next;
        m_run_end_reg   <= m_run_end_next;
    end

    `GDFD_ASSERT_NXT(a_single_point_run, aclk, aresetn,
        in_acc && s_last && points_seen_reg == 2'd0,
        state_reg == S_IDLE && points_seen_reg == 2'd0)
    `GDFD_ASSERT_IMP(a_zero_step_delay, aclk, aresetn,
        m_valid_reg && m_status_reg == STATUS_ZERO, m_delay_reg == '0)
    `GDFD_ASSERT_IMP(a_sat_at_limit, aclk, aresetn,
        m_valid_reg && m_status_reg == STATUS_SAT,
        m_delay_reg == DELAY_POS_MAX || m_delay_reg == DELAY_NEG_MAX)
    `GDFD_ASSERT_IMP(a_points_seen_range, aclk, aresetn, 1'b1, points_seen_reg != 2'd3)

endmodule

/* sim/tb_group_delay_finite_difference.sv */
module tb_group_delay_finite_difference;
    timeunit 1ns;
    timeprecision 1ps;

    import gdfd_pkg::*;

    localparam int STUCK_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 200;
    localparam int POINTS_PER_PHASE = 490;

    typedef struct {
        logic signed [DELAY_BITS-1:0] delay;
        status_t                      status;
        logic                         run_end;
    } delay_result_t;

    typedef struct {
        logic signed [PHASE_BITS-1:0] ph;
        logic        [OMEGA_BITS-1:0] om;
        logic                         lst;
        int                           typed_n;
        delay_result_t                t0;
        delay_result_t                t1;
    } stim_row_t;

    logic                         aclk = 1'b0;
    logic                         aresetn = 1'b0;
    logic                         s_valid = 1'b0;
    logic                         s_ready;
    logic signed [PHASE_BITS-1:0] s_phase = '0;
    logic        [OMEGA_BITS-1:0] s_omega = '0;
    logic                         s_last = 1'b0;
    logic                         m_valid;
    logic                         m_ready = 1'b0;
    logic signed [DELAY_BITS-1:0] m_delay;
    status_t                      m_status;
    logic                         m_run_end;

    group_delay_finite_difference dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_phase  (s_phase),
        .s_omega  (s_omega),
        .s_last   (s_last),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_delay  (m_delay),
        .m_status (m_status),
        .m_run_end(m_run_end)
    );

    always #5 aclk = ~aclk;

    delay_result_t expected_delays[$];
    stim_row_t     directed_rows[$];

    // sweep history kept by the predictor
    logic signed [PHASE_BITS-1:0] hist_ph_new, hist_ph_old;
    logic        [OMEGA_BITS-1:0] hist_om_new, hist_om_old;
    int                           hist_count = 0;

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int sent_points = 0;
    int delays_checked = 0;
    int sat_seen = 0;
    int zero_step_seen = 0;
    int run_ends_seen = 0;
    int mismatches = 0;
    int stuck_cycles = 0;

    task automatic flag_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatches++;
    endtask

    // -(pb - pa) / (wb - wa), Q8.24 / Q32.8 -> Q8.40, truncated toward zero
    function automatic delay_result_t slope_delay(
        input logic signed [PHASE_BITS-1:0] pa,
        input logic        [OMEGA_BITS-1:0] wa,
        input logic signed [PHASE_BITS-1:0] pb,
        input logic        [OMEGA_BITS-1:0] wb,
        input logic                         end_of_run
    );
        longint        dp;
        longint        dw;
        logic   [63:0] mag_p;
        logic   [63:0] mag_w;
        logic   [63:0] quo;
        logic   [63:0] cap;
        logic          flip;
        delay_result_t r;
        dp = longint'(pb) - longint'(pa);
        dw = longint'({24'd0, wb}) - longint'({24'd0, wa});
        r.run_end = end_of_run;
        if (dw == 0) begin
            r.delay = '0;
            r.status = STATUS_ZERO;
            return r;
        end
        mag_p = (dp < 0) ? 64'(-dp) : 64'(dp);
        mag_w = (dw < 0) ? 64'(-dw) : 64'(dw);
        flip = ((dp < 0) == (dw < 0));
        cap = flip ? 64'(DELAY_POS_MAX) + 64'd1 : 64'(DELAY_POS_MAX);
        quo = (mag_p << FRAC_SHIFT) / mag_w;
        r.status = STATUS_OK;
        if (quo > cap) begin
            quo = cap;
            r.status = STATUS_SAT;
        end
        if (quo == 0)
            flip = 1'b0;
        r.delay = DELAY_BITS'(flip ? -quo : quo);
        return r;
    endfunction

    task automatic predict_point(
        input  logic signed [PHASE_BITS-1:0] ph,
        input  logic        [OMEGA_BITS-1:0] om,
        input  logic                         lst,
        output int                           n,
        output delay_result_t                r0,
        output delay_result_t                r1
    );
        n = 0;
        if (hist_count == 0) begin
            if (!lst) begin
                hist_ph_new = ph;
                hist_om_new = om;
                hist_count = 1;
            end
            return;
        end
        if (hist_count == 1)
            r0 = slope_delay(hist_ph_new, hist_om_new, ph, om, 1'b0);
        else
            r0 = slope_delay(hist_ph_old, hist_om_old, ph, om, 1'b0);
        n = 1;
        if (lst) begin
            r1 = slope_delay(hist_ph_new, hist_om_new, ph, om, 1'b1);
            n = 2;
            hist_count = 0;
            return;
        end
        hist_ph_old = hist_ph_new;
        hist_om_old = hist_om_new;
        hist_ph_new = ph;
        hist_om_new = om;
        hist_count = 2;
    endtask

    // Called at a rising edge; returns at the edge where the request is taken.
    task automatic send_point(
        input logic signed [PHASE_BITS-1:0] ph,
        input logic        [OMEGA_BITS-1:0] om,
        input logic                         lst,
        input int                           typed_n,
        input delay_result_t                t0,
        input delay_result_t                t1
    );
        int            n;
        delay_result_t p0;
        delay_result_t p1;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_phase <= ph;
        s_omega <= om;
        s_last <= lst;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        sent_points++;
        predict_point(ph, om, lst, n, p0, p1);
        if (typed_n >= 0) begin
            n = typed_n;
            p0 = t0;
            p1 = t1;
        end
        if (n > 0)
            expected_delays.push_back(p0);
        if (n > 1)
            expected_delays.push_back(p1);
    endtask

    task automatic add_row(
        input logic signed [PHASE_BITS-1:0] ph,
        input logic        [OMEGA_BITS-1:0] om,
        input logic                         lst,
        input int                           typed_n,
        input logic signed [DELAY_BITS-1:0] d0,
        input status_t                      st0,
        input logic signed [DELAY_BITS-1:0] d1,
        input status_t                      st1
    );
        stim_row_t row;
        row.ph = ph;
        row.om = om;
        row.lst = lst;
        row.typed_n = typed_n;
        row.t0 = '{d0, st0, 1'b0};
        row.t1 = '{d1, st1, 1'b1};
        directed_rows.push_back(row);
    endtask

    function automatic logic [OMEGA_BITS-1:0] rand_omega();
        return {8'($urandom), 32'($urandom)};
    endfunction

    task automatic wait_all_delays();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_delays.size() != 0)
            @(posedge aclk);
    endtask

    task automatic send_sweep();
        int                           len;
        int                           style;
        int                           pick;
        int unsigned                  mag;
        logic signed [PHASE_BITS-1:0] ph;
        logic signed [PHASE_BITS-1:0] dph;
        logic        [OMEGA_BITS-1:0] om;
        logic        [OMEGA_BITS-1:0] step;
        delay_result_t                none;
        none = '{'0, STATUS_OK, 1'b0};
        pick = $urandom_range(99);
        if (pick < 8)
            len = 1;
        else if (pick < 16)
            len = 2;
        else
            len = $urandom_range(3, 16);
        style = $urandom_range(3);
        ph = $urandom;
        om = rand_omega() >> $urandom_range(0, 39);
        step = rand_omega() >> $urandom_range(6, 39);
        mag = $urandom >> $urandom_range(1, 31);
        dph = ($urandom_range(3) == 0) ? PHASE_BITS'(mag) : -PHASE_BITS'(mag);
        for (int k = 0; k < len; k++) begin
            if (style == 2) begin
                ph = $urandom;
                om = rand_omega();
            end else if (k > 0) begin
                ph = ph + dph + PHASE_BITS'(int'($urandom_range(64)) - 32);
                pick = $urandom_range(99);
                if (style != 3 || pick >= 30)
                    om = om + step;
                else if (pick >= 20)
                    om = om - step;
            end
            send_point(ph, om, k == len - 1, -1, none, none);
        end
    endtask

    // result side: random stall, compare every transfer with the oldest prediction
    always @(posedge aclk) begin
        delay_result_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                delays_checked++;
                if (m_status == STATUS_SAT)
                    sat_seen++;
                if (m_status == STATUS_ZERO)
                    zero_step_seen++;
                if (m_run_end)
                    run_ends_seen++;
                if (expected_delays.size() == 0) begin
                    flag_mismatch($sformatf("unexpected delay %0d status %0d run_end %0d",
                                            m_delay, m_status, m_run_end));
                end else begin
                    want = expected_delays.pop_front();
                    if (m_delay !== want.delay)
                        flag_mismatch($sformatf("delay %0d, predicted %0d",
                                                m_delay, want.delay));
                    if (m_status !== want.status)
                        flag_mismatch($sformatf("status %0d, predicted %0d",
                                                m_status, want.status));
                    if (m_run_end !== want.run_end)
                        flag_mismatch($sformatf("run_end %0d, predicted %0d",
                                                m_run_end, want.run_end));
                end
            end
            m_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            stuck_cycles <= 0;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("timeout: no request moved for %0d cycles", stuck_cycles);
                $display("FAIL");
                $finish;
            end
        end
    end

    initial begin : main_seq
        int idle_pct[4];
        int stall_pct[4];
        int phase_start;
        idle_pct = '{0, 69, 0, 10};
        stall_pct = '{0, 0, 69, 10};

        // run of one point right after reset
        add_row(0, 0, 1'b1, 0, '0, STATUS_OK, '0, STATUS_OK);
        // zero frequency step on both ends of a two point run
        add_row(0, 0, 1'b0, 0, '0, STATUS_OK, '0, STATUS_OK);
        add_row(0, 0, 1'b1, 2, '0, STATUS_ZERO, '0, STATUS_ZERO);
        // full-scale phase swing over one omega LSB
        add_row(32'sh8000_0000, 0, 1'b0, 0, '0, STATUS_OK, '0, STATUS_OK);
        add_row(32'sh7fff_ffff, 1, 1'b1, 2, DELAY_NEG_MAX, STATUS_SAT, DELAY_NEG_MAX, STATUS_SAT);
        add_row(32'sh7fff_ffff, 0, 1'b0, 0, '0, STATUS_OK, '0, STATUS_OK);
        add_row(32'sh8000_0000, 1, 1'b1, 2, DELAY_POS_MAX, STATUS_SAT, DELAY_POS_MAX, STATUS_SAT);
        // flat phase
        add_row(5, 100, 1'b0, 0, '0, STATUS_OK, '0, STATUS_OK);
        add_row(5, 200, 1'b1, 2, '0, STATUS_OK, '0, STATUS_OK);
        // omega extremes
        add_row(32'sh7fff_ffff, 40'hff_ffff_ffff, 1'b0, -1, '0, STATUS_OK, '0, STATUS_OK);
        add_row(32'sh8000_0000, 0, 1'b1, -1, '0, STATUS_OK, '0, STATUS_OK);
        // three points: forward, central, backward
        add_row(32'sh0100_0000, 256, 1'b0, -1, '0, STATUS_OK, '0, STATUS_OK);
        add_row(32'sh0080_0000, 512, 1'b0, -1, '0, STATUS_OK, '0, STATUS_OK);
        add_row(0, 768, 1'b1, -1, '0, STATUS_OK, '0, STATUS_OK);
        // central difference across equal neighbor frequencies
        add_row(100, 10, 1'b0, -1, '0, STATUS_OK, '0, STATUS_OK);
        add_row(-100, 20, 1'b0, -1, '0, STATUS_OK, '0, STATUS_OK);
        add_row(300, 10, 1'b0, -1, '0, STATUS_OK, '0, STATUS_OK);
        add_row(7, 40, 1'b1, -1, '0, STATUS_OK, '0, STATUS_OK);
        // falling omega
        add_row(-1, 40'hff_ffff_ffff, 1'b0, -1, '0, STATUS_OK, '0, STATUS_OK);
        add_row(32'sh8000_0000, 40'h80_0000_0000, 1'b0, -1, '0, STATUS_OK, '0, STATUS_OK);
        add_row(32'sh7fff_ffff, 1, 1'b1, -1, '0, STATUS_OK, '0, STATUS_OK);

        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i])
            send_point(directed_rows[i].ph, directed_rows[i].om, directed_rows[i].lst,
                       directed_rows[i].typed_n, directed_rows[i].t0, directed_rows[i].t1);
        wait_all_delays();

        for (int p = 0; p < 4; p++) begin
            send_idle_pct = idle_pct[p];
            recv_stall_pct = stall_pct[p];
            phase_start = sent_points;
            while (sent_points - phase_start < POINTS_PER_PHASE)
                send_sweep();
            // hold the sender off until the pipeline is empty
            wait_all_delays();
        end

        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("%0d sweep points sent, %0d delays checked (%0d run ends)",
                 sent_points, delays_checked, run_ends_seen);
        $display("%0d saturated and %0d zero-step results, %0d mismatches",
                 sat_seen, zero_step_seen, mismatches);
        if (mismatches == 0 && expected_delays.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
